/* src/gsli_pkg.sv */
// ----------------------------------------------------------------------------
// gsli_pkg
// Shared types and codes for the grouped sorted list insert block.
// ----------------------------------------------------------------------------
package gsli_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned EmitW  = 32;
  localparam int unsigned VolW   = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [0:0] {
    REQ_INSERT = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_LINK,
    ST_RESULT
  } state_e;

endpackage

/* src/gsli_group_mem.sv */
// ----------------------------------------------------------------------------
// gsli_group_mem
// Group table: key, list head and node count per group slot, one read port
// with registered data and one write port.
// ----------------------------------------------------------------------------
module gsli_group_mem import gsli_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned LinkW = 7
) (
  input  logic              clk_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [KeyW-1:0]   rd_key_o,
  output logic [LinkW-1:0]  rd_head_o,
  output logic [LinkW:0]    rd_count_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [KeyW-1:0]   wr_key_i,
  input  logic [LinkW-1:0]  wr_head_i,
  input  logic [LinkW:0]    wr_count_i
);

  logic [KeyW-1:0]  key_mem   [Depth];
  logic [LinkW-1:0] head_mem  [Depth];
  logic [LinkW:0]   count_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]   <= wr_key_i;
      head_mem[wr_addr_i]  <= wr_head_i;
      count_mem[wr_addr_i] <= wr_count_i;
    end
    rd_key_o   <= key_mem[rd_addr_i];
    rd_head_o  <= head_mem[rd_addr_i];
    rd_count_o <= count_mem[rd_addr_i];
  end

endmodule

/* src/gsli_node_mem.sv */
// ----------------------------------------------------------------------------
// gsli_node_mem
// Node pool: next link, volume and emitter per node, one read port with
// registered data, a full write port (new node) and a narrow one (relinked node).
// ----------------------------------------------------------------------------
module gsli_node_mem import gsli_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned LinkW = 7
) (
  input  logic              clk_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [LinkW-1:0]  rd_next_o,
  output logic [VolW-1:0]   rd_vol_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [LinkW-1:0]  wr_next_i,
  input  logic [VolW-1:0]   wr_vol_i,
  input  logic [EmitW-1:0]  wr_emit_i,
  input  logic              ln_en_i,
  input  logic [AddrW-1:0]  ln_addr_i,
  input  logic [LinkW-1:0]  ln_next_i
);

  logic [LinkW-1:0] next_mem [Depth];
  logic [VolW-1:0]  vol_mem  [Depth];
  logic [EmitW-1:0] emit_mem [Depth];

  // The relink write and the new-node write never target the same entry.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      next_mem[wr_addr_i] <= wr_next_i;
      vol_mem[wr_addr_i]  <= wr_vol_i;
      emit_mem[wr_addr_i] <= wr_emit_i;
    end
    if (ln_en_i) begin
      next_mem[ln_addr_i] <= ln_next_i;
    end
    rd_next_o <= next_mem[rd_addr_i];
    rd_vol_o  <= vol_mem[rd_addr_i];
  end

endmodule

/* src/grouped_sorted_list_insert.sv */
// ----------------------------------------------------------------------------
// grouped_sorted_list_insert
// Groups emitters by key and keeps each group's nodes in a volume-sorted list.
// ----------------------------------------------------------------------------
// Usage: one input channel (req_valid_i/req_ready_o) carries a request type,
// group key, emitter id and volume. One output channel (rsp_valid_o /
// rsp_ready_i) returns exactly one result transaction per request.
// An insert scans the group table slot by slot (read, then compare), reads
// the group's head (read, then check), walks the list node by node (read,
// then compare) and links the new node. The walk stops on the first node
// with a larger volume, or at the end of the list; the insert rank is the
// number of nodes passed. Every earlier group holds at least one node of
// the shared pool. A new group is linked straight after the scan of the N
// groups in use; with the table empty the scan reads no slot. Every search
// and walk step waits on the registered read data of its memory.
// A clear transaction just zeroes the two fill counters and its result is
// valid on the next cycle; a full pool is reported just as fast. A full table
// or pool drops the insert and reports full_flag.
// Reset clears the fill counters; memory contents need no clearing.
// One request is handled at a time; while the result waits on a stalled
// receiver the next request is not taken until that result is accepted.
// ----------------------------------------------------------------------------
module grouped_sorted_list_insert import gsli_pkg::*; #(
  parameter int unsigned MAX_GROUPS = 64,
  parameter int unsigned POOL_NODES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               req_type_i,
  input  logic [KeyW-1:0]    group_key_i,
  input  logic [EmitW-1:0]   emitter_id_i,
  input  logic [VolW-1:0]    volume_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [IdxW-1:0]    group_index_o,
  output logic               group_created_o,
  output logic [IdxW-1:0]    insert_rank_o,
  output logic [CountW-1:0]  running_count_o,
  output logic               full_flag_o
);

  localparam int unsigned GAW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned NAW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned GCW = $clog2(MAX_GROUPS + 1);
  localparam int unsigned LW  = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0]  NIL    = LW'(POOL_NODES);
  localparam logic [GCW-1:0] GFULL  = GCW'(MAX_GROUPS);

  state_e state_q, state_d;

  logic [KeyW-1:0]  key_q;
  logic [EmitW-1:0] emit_q;
  logic [VolW-1:0]  vol_q;
  logic [GCW-1:0]   groups_q, groups_d;
  logic [LW-1:0]    nodes_q, nodes_d;
  logic [GCW-1:0]   gi_q, gi_d;
  logic             created_q, created_d;
  logic [LW-1:0]    node_q, node_d;
  logic [LW-1:0]    prev_q, prev_d;
  logic [LW-1:0]    head_q, head_d;
  logic [LW:0]      cnt_q, cnt_d;
  logic [LW-1:0]    rank_q, rank_d;
  logic             full_q, full_d;

  // memory ports
  logic [GAW-1:0]   g_rd_addr;
  logic [KeyW-1:0]  g_rd_key;
  logic [LW-1:0]    g_rd_head;
  logic [LW:0]      g_rd_count;
  logic             g_wr_en;
  logic [LW-1:0]    n_rd_next;
  logic [VolW-1:0]  n_rd_vol;
  logic             n_wr_en;
  logic             n_ln_en;

  gsli_group_mem #(.Depth(MAX_GROUPS), .AddrW(GAW), .LinkW(LW)) u_group_mem (
    .clk_i      (clk_i),
    .rd_addr_i  (g_rd_addr),
    .rd_key_o   (g_rd_key),
    .rd_head_o  (g_rd_head),
    .rd_count_o (g_rd_count),
    .wr_en_i    (g_wr_en),
    .wr_addr_i  (gi_q[GAW-1:0]),
    .wr_key_i   (key_q),
    .wr_head_i  ((prev_q == NIL) ? nodes_q : head_q),
    .wr_count_i (cnt_q + 1'b1)
  );

  gsli_node_mem #(.Depth(POOL_NODES), .AddrW(NAW), .LinkW(LW)) u_node_mem (
    .clk_i     (clk_i),
    .rd_addr_i (node_q[NAW-1:0]),
    .rd_next_o (n_rd_next),
    .rd_vol_o  (n_rd_vol),
    .wr_en_i   (n_wr_en),
    .wr_addr_i (nodes_q[NAW-1:0]),
    .wr_next_i (node_q),
    .wr_vol_i  (vol_q),
    .wr_emit_i (emit_q),
    .ln_en_i   (n_ln_en),
    .ln_addr_i (prev_q[NAW-1:0]),
    .ln_next_i (nodes_q)
  );

  assign g_rd_addr = gi_q[GAW-1:0];

  // Next-state logic.
  always_comb begin
    state_d   = state_q;
    groups_d  = groups_q;
    nodes_d   = nodes_q;
    gi_d      = gi_q;
    created_d = created_q;
    node_d    = node_q;
    prev_d    = prev_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    rank_d    = rank_q;
    full_d    = full_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          gi_d      = '0;
          created_d = 1'b0;
          rank_d    = '0;
          full_d    = 1'b0;
          prev_d    = NIL;
          if (req_type_i == REQ_CLEAR) begin
            groups_d = '0;
            nodes_d  = '0;
            cnt_d    = '0;
            state_d  = ST_RESULT;
          end else if (nodes_q == NIL) begin
            full_d  = 1'b1;
            state_d = ST_RESULT;
          end else if (groups_q == '0) begin
            state_d = ST_SRCH_CHK;
          end else begin
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: state_d = ST_SRCH_CHK;
      ST_SRCH_CHK: begin
        if (gi_q < groups_q && g_rd_key == key_q) begin
          state_d = ST_HEAD_RD;
        end else if (gi_q >= groups_q) begin
          if (groups_q == GFULL) begin
            full_d  = 1'b1;
            state_d = ST_RESULT;
          end else begin
            created_d = 1'b1;
            groups_d  = groups_q + 1'b1;
            head_d    = NIL;
            node_d    = NIL;
            cnt_d     = '0;
            state_d   = ST_LINK;
          end
        end else begin
          gi_d    = gi_q + 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_HEAD_RD: state_d = ST_HEAD_CHK;
      ST_HEAD_CHK: begin
        head_d = g_rd_head;
        cnt_d  = g_rd_count;
        node_d = g_rd_head;
        state_d = (g_rd_head >= NIL) ? ST_LINK : ST_WALK_RD;
      end
      ST_WALK_RD: state_d = ST_WALK_CHK;
      ST_WALK_CHK: begin
        if (n_rd_vol > vol_q) begin
          state_d = ST_LINK;
        end else begin
          prev_d = node_q;
          node_d = n_rd_next;
          rank_d = rank_q + 1'b1;
          state_d = (n_rd_next >= NIL) ? ST_LINK : ST_WALK_RD;
        end
      end
      ST_LINK: begin
        nodes_d = nodes_q + 1'b1;
        cnt_d   = cnt_q + 1'b1;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (rsp_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and write-enable logic.
  always_comb begin
    req_ready_o = (state_q == ST_IDLE);
    rsp_valid_o = (state_q == ST_RESULT);
    g_wr_en     = (state_q == ST_LINK);
    n_wr_en     = (state_q == ST_LINK);
    n_ln_en     = (state_q == ST_LINK) && (prev_q != NIL);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_valid_i) begin
      key_q  <= group_key_i;
      emit_q <= emitter_id_i;
      vol_q  <= volume_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      groups_q  <= '0;
      nodes_q   <= '0;
      gi_q      <= '0;
      created_q <= 1'b0;
      node_q    <= '0;
      prev_q    <= '0;
      head_q    <= '0;
      cnt_q     <= '0;
      rank_q    <= '0;
      full_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      groups_q  <= groups_d;
      nodes_q   <= nodes_d;
      gi_q      <= gi_d;
      created_q <= created_d;
      node_q    <= node_d;
      prev_q    <= prev_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      rank_q    <= rank_d;
      full_q    <= full_d;
    end
  end

  // Dropped and clear transactions report zero in every field but full_flag.
  assign group_index_o   = full_q ? '0 : IdxW'(gi_q);
  assign group_created_o = full_q ? 1'b0 : created_q;
  assign insert_rank_o   = full_q ? '0 : IdxW'(rank_q);
  assign running_count_o = full_q ? '0 : CountW'(cnt_q);
  assign full_flag_o     = full_q;

endmodule
